### rtl/core/pfst_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pfst_pkg: shared types and constants of the format specifier tokenizer
// Holds the phase encoding, flag bit positions, result kinds and the
// command and status bundles that join the controller and the datapath.
// ============================================================================
package pfst_pkg;

    // Parse phase of an open specifier.
    typedef enum logic [3:0] {
        PH_LIT,
        PH_FLAGS,
        PH_WIDTH,
        PH_WSTAR,
        PH_DOT,
        PH_PREC,
        PH_PSTAR,
        PH_L,
        PH_H,
        PH_SPEC
    } phase_t;

    // What the current specifier does with the incoming byte.
    typedef enum logic [1:0] {
        TK_REJECT,
        TK_CONSUME,
        TK_CLOSE
    } take_t;

    // Source of the next result loaded into the output register.
    typedef enum logic [2:0] {
        OS_LIT_IN,
        OS_LIT_HELD,
        OS_DESC,
        OS_ECHO,
        OS_END,
        OS_END_CLEAN
    } out_sel_t;

    // Update applied to the specifier state.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_OPEN,
        OP_TAKE,
        OP_CLOSE
    } spec_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_RD,
        CS_WR,
        CS_END,
        CS_LIT,
        CS_ENDC
    } ctrl_state_t;

    // Work left after the end marker of a rejected specifier.
    typedef enum logic [1:0] {
        PA_NONE,
        PA_LIT,
        PA_OPEN,
        PA_END
    } post_t;

    typedef struct packed {
        spec_op_t op;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     hold;
        logic     idx_clr;
        logic     idx_inc;
        logic     rd_issue;
    } cmd_t;

    typedef struct packed {
        logic  in_lit;
        logic  ch_pct;
        take_t take;
        logic  out_free;
        logic  echo_more;
    } status_t;

    // Result kinds.
    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_SPEC = 2'd1;
    localparam logic [1:0] KIND_ECHO = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // Flag bit positions.
    localparam int FB_ZEROPAD = 0;
    localparam int FB_LEFT    = 1;
    localparam int FB_PLUS    = 2;
    localparam int FB_SPACE   = 3;
    localparam int FB_HASH    = 4;
    localparam int FB_WSTAR   = 5;
    localparam int FB_PSTAR   = 6;
    localparam int FB_CHAR    = 7;
    localparam int FB_SHORT   = 8;
    localparam int FB_LONG    = 9;
    localparam int FB_LLONG   = 10;
    localparam int FB_HASW    = 11;
    localparam int FB_HASP    = 12;

    localparam int FLAG_W = 13;
    localparam int NUM_W  = 16;
    localparam logic [19:0] SAT_MAX = 20'd65535;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOT  = 8'h2E;

endpackage

### rtl/core/pfst_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// pfst_ctrl: tokenizer controller
// Accepts input bytes and sequences the echo of a rejected specifier.
// ============================================================================
module pfst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  pfst_pkg::status_t status,
    output pfst_pkg::cmd_t    cmd
);

    pfst_pkg::ctrl_state_t state_reg, state_next;
    pfst_pkg::post_t       post_reg, post_next;
    logic                  accept;

    assign s_tready = (state_reg == pfst_pkg::CS_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfst_pkg::CS_IDLE;
            post_reg  <= pfst_pkg::PA_NONE;
        end else begin
            state_reg <= state_next;
            post_reg  <= post_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        post_next    = post_reg;
        cmd          = '0;
        cmd.op       = pfst_pkg::OP_NONE;
        cmd.out_sel  = pfst_pkg::OS_LIT_IN;
        unique case (state_reg)
            pfst_pkg::CS_IDLE: begin
                if (accept) begin
                    if (status.in_lit) begin
                        if (!status.ch_pct) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = pfst_pkg::OS_LIT_IN;
                            cmd.out_last = 1'b1;
                        end else if (s_tlast) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = pfst_pkg::OS_END_CLEAN;
                            cmd.out_last = 1'b1;
                        end else begin
                            cmd.op = pfst_pkg::OP_OPEN;
                        end
                    end else begin
                        unique case (status.take)
                            pfst_pkg::TK_CLOSE: begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = pfst_pkg::OS_DESC;
                                cmd.out_last = 1'b1;
                                cmd.op       = pfst_pkg::OP_CLOSE;
                            end
                            pfst_pkg::TK_CONSUME: begin
                                cmd.op = pfst_pkg::OP_TAKE;
                                if (s_tlast) begin
                                    cmd.idx_clr = 1'b1;
                                    post_next   = pfst_pkg::PA_NONE;
                                    state_next  = pfst_pkg::CS_RD;
                                end
                            end
                            default: begin
                                cmd.hold    = 1'b1;
                                cmd.idx_clr = 1'b1;
                                if (!status.ch_pct) begin
                                    post_next = pfst_pkg::PA_LIT;
                                end else if (s_tlast) begin
                                    post_next = pfst_pkg::PA_END;
                                end else begin
                                    post_next = pfst_pkg::PA_OPEN;
                                end
                                state_next = pfst_pkg::CS_RD;
                            end
                        endcase
                    end
                end
            end
            pfst_pkg::CS_RD: begin
                if (status.echo_more) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = pfst_pkg::CS_WR;
                end else begin
                    state_next = pfst_pkg::CS_END;
                end
            end
            pfst_pkg::CS_WR: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pfst_pkg::OS_ECHO;
                    cmd.idx_inc  = 1'b1;
                    state_next   = pfst_pkg::CS_RD;
                end
            end
            pfst_pkg::CS_END: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pfst_pkg::OS_END;
                    cmd.out_last = (post_reg == pfst_pkg::PA_NONE) ||
                                   (post_reg == pfst_pkg::PA_OPEN);
                    cmd.op       = (post_reg == pfst_pkg::PA_OPEN) ?
                                   pfst_pkg::OP_OPEN : pfst_pkg::OP_CLOSE;
                    unique case (post_reg)
                        pfst_pkg::PA_LIT: state_next = pfst_pkg::CS_LIT;
                        pfst_pkg::PA_END: state_next = pfst_pkg::CS_ENDC;
                        default:          state_next = pfst_pkg::CS_IDLE;
                    endcase
                end
            end
            pfst_pkg::CS_LIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pfst_pkg::OS_LIT_HELD;
                    cmd.out_last = 1'b1;
                    state_next   = pfst_pkg::CS_IDLE;
                end
            end
            pfst_pkg::CS_ENDC: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pfst_pkg::OS_END_CLEAN;
                    cmd.out_last = 1'b1;
                    state_next   = pfst_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = pfst_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/pfst_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// pfst_dpath: tokenizer datapath
// Specifier state, echo buffer, byte classification and the output register.
// ============================================================================
module pfst_dpath #(
    parameter int ECHO_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_data,
    input  logic [7:0]                      in_ch,
    input  logic                            m_tready,
    input  pfst_pkg::cmd_t                  cmd,
    output pfst_pkg::status_t               status,
    output logic                            out_valid,
    output logic [1:0]                      out_kind,
    output logic [7:0]                      out_text,
    output logic [pfst_pkg::FLAG_W-1:0]     out_flags,
    output logic [pfst_pkg::NUM_W-1:0]      out_width,
    output logic [pfst_pkg::NUM_W-1:0]      out_prec,
    output logic [7:0]                      out_conv,
    output logic                            out_ovf,
    output logic                            out_last
);

    localparam int CW = $clog2(ECHO_DEPTH + 1);
    localparam int IW = $clog2(ECHO_DEPTH);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_conv(input logic [7:0] c);
        logic r;
        case (c)
            "d", "i", "u", "x", "X", "o", "b", "f", "F", "e", "E",
            "g", "G", "c", "s", "p", pfst_pkg::CH_PCT: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // acc * 10 + d as shift-and-add, saturated to 16 bits.
    function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
        return (v > pfst_pkg::SAT_MAX) ? 16'hFFFF : v[15:0];
    endfunction

    logic                        size_long_reg;
    pfst_pkg::phase_t            phase_reg, phase_next;
    logic [pfst_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic [pfst_pkg::NUM_W-1:0]  width_reg, width_next;
    logic [pfst_pkg::NUM_W-1:0]  prec_reg, prec_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        lost_reg, lost_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [7:0]                  ch_reg;
    logic [7:0]                  rd_data_reg;
    logic [7:0]                  echo_mem [ECHO_DEPTH];
    logic                        echo_wr;

    pfst_pkg::take_t             take;
    pfst_pkg::phase_t            tk_phase;
    logic [pfst_pkg::FLAG_W-1:0] tk_flags;
    logic [pfst_pkg::NUM_W-1:0]  tk_width;
    logic [pfst_pkg::NUM_W-1:0]  tk_prec;
    logic                        in_body;
    logic                        out_valid_reg, out_valid_next;

    assign in_body = (phase_reg == pfst_pkg::PH_FLAGS) || (phase_reg == pfst_pkg::PH_WIDTH) ||
                     (phase_reg == pfst_pkg::PH_WSTAR) || (phase_reg == pfst_pkg::PH_DOT) ||
                     (phase_reg == pfst_pkg::PH_PREC) || (phase_reg == pfst_pkg::PH_PSTAR);

    // Classification of the incoming byte against the open specifier.
    always_comb begin
        take     = pfst_pkg::TK_CONSUME;
        tk_phase = phase_reg;
        tk_flags = flags_reg;
        tk_width = width_reg;
        tk_prec  = prec_reg;
        if (phase_reg == pfst_pkg::PH_FLAGS && in_ch == "0") begin
            tk_flags[pfst_pkg::FB_ZEROPAD] = 1'b1;
        end else if (phase_reg == pfst_pkg::PH_FLAGS && in_ch == "-") begin
            tk_flags[pfst_pkg::FB_LEFT] = 1'b1;
        end else if (phase_reg == pfst_pkg::PH_FLAGS && in_ch == "+") begin
            tk_flags[pfst_pkg::FB_PLUS] = 1'b1;
        end else if (phase_reg == pfst_pkg::PH_FLAGS && in_ch == " ") begin
            tk_flags[pfst_pkg::FB_SPACE] = 1'b1;
        end else if (phase_reg == pfst_pkg::PH_FLAGS && in_ch == "#") begin
            tk_flags[pfst_pkg::FB_HASH] = 1'b1;
        end else if (phase_reg == pfst_pkg::PH_FLAGS && is_digit(in_ch)) begin
            tk_flags[pfst_pkg::FB_HASW] = 1'b1;
            tk_width = {12'b0, in_ch[3:0]};
            tk_phase = pfst_pkg::PH_WIDTH;
        end else if (phase_reg == pfst_pkg::PH_FLAGS && in_ch == pfst_pkg::CH_STAR) begin
            tk_flags[pfst_pkg::FB_HASW]  = 1'b1;
            tk_flags[pfst_pkg::FB_WSTAR] = 1'b1;
            tk_phase = pfst_pkg::PH_WSTAR;
        end else if (phase_reg == pfst_pkg::PH_WIDTH && is_digit(in_ch)) begin
            tk_width = acc_digit(width_reg, in_ch[3:0]);
        end else if ((phase_reg == pfst_pkg::PH_FLAGS || phase_reg == pfst_pkg::PH_WIDTH ||
                      phase_reg == pfst_pkg::PH_WSTAR) && in_ch == pfst_pkg::CH_DOT) begin
            tk_flags[pfst_pkg::FB_HASP] = 1'b1;
            tk_phase = pfst_pkg::PH_DOT;
        end else if (phase_reg == pfst_pkg::PH_DOT && is_digit(in_ch)) begin
            tk_prec  = {12'b0, in_ch[3:0]};
            tk_phase = pfst_pkg::PH_PREC;
        end else if (phase_reg == pfst_pkg::PH_DOT && in_ch == pfst_pkg::CH_STAR) begin
            tk_flags[pfst_pkg::FB_PSTAR] = 1'b1;
            tk_phase = pfst_pkg::PH_PSTAR;
        end else if (phase_reg == pfst_pkg::PH_PREC && is_digit(in_ch)) begin
            tk_prec = acc_digit(prec_reg, in_ch[3:0]);
        end else if (in_body && in_ch == "l") begin
            tk_flags[pfst_pkg::FB_LONG] = 1'b1;
            tk_phase = pfst_pkg::PH_L;
        end else if (in_body && in_ch == "h") begin
            tk_flags[pfst_pkg::FB_SHORT] = 1'b1;
            tk_phase = pfst_pkg::PH_H;
        end else if (in_body && (in_ch == "t" || in_ch == "j" || in_ch == "z")) begin
            if (size_long_reg) begin
                tk_flags[pfst_pkg::FB_LONG] = 1'b1;
            end else begin
                tk_flags[pfst_pkg::FB_LLONG] = 1'b1;
            end
            tk_phase = pfst_pkg::PH_SPEC;
        end else if (phase_reg == pfst_pkg::PH_L && in_ch == "l") begin
            tk_flags[pfst_pkg::FB_LLONG] = 1'b1;
            tk_phase = pfst_pkg::PH_SPEC;
        end else if (phase_reg == pfst_pkg::PH_H && in_ch == "h") begin
            tk_flags[pfst_pkg::FB_CHAR] = 1'b1;
            tk_phase = pfst_pkg::PH_SPEC;
        end else if (is_conv(in_ch)) begin
            take = pfst_pkg::TK_CLOSE;
        end else begin
            take = pfst_pkg::TK_REJECT;
        end
    end

    assign status.in_lit    = (phase_reg == pfst_pkg::PH_LIT);
    assign status.ch_pct    = (in_ch == pfst_pkg::CH_PCT);
    assign status.take      = take;
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.echo_more = (idx_reg < cnt_reg);

    // Specifier state update.
    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        width_next = width_reg;
        prec_next  = prec_reg;
        cnt_next   = cnt_reg;
        lost_next  = lost_reg;
        echo_wr    = 1'b0;
        case (cmd.op)
            pfst_pkg::OP_OPEN: begin
                phase_next = pfst_pkg::PH_FLAGS;
                flags_next = '0;
                width_next = '0;
                prec_next  = '0;
                cnt_next   = '0;
                lost_next  = 1'b0;
            end
            pfst_pkg::OP_TAKE: begin
                phase_next = tk_phase;
                flags_next = tk_flags;
                width_next = tk_width;
                prec_next  = tk_prec;
                if (cnt_reg < CW'(ECHO_DEPTH)) begin
                    echo_wr  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    lost_next = 1'b1;
                end
            end
            pfst_pkg::OP_CLOSE: begin
                phase_next = pfst_pkg::PH_LIT;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_long_reg <= 1'b1;
            phase_reg     <= pfst_pkg::PH_LIT;
            flags_reg     <= '0;
            width_reg     <= '0;
            prec_reg      <= '0;
            cnt_reg       <= '0;
            lost_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                size_long_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            width_reg     <= width_next;
            prec_reg      <= prec_next;
            cnt_reg       <= cnt_next;
            lost_reg      <= lost_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Echo memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (echo_wr) begin
            echo_mem[cnt_reg[IW-1:0]] <= in_ch;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= echo_mem[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hold) begin
            ch_reg <= in_ch;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_kind  <= pfst_pkg::KIND_LIT;
            out_text  <= '0;
            out_flags <= '0;
            out_width <= '0;
            out_prec  <= '0;
            out_conv  <= '0;
            out_ovf   <= 1'b0;
            out_last  <= cmd.out_last;
            case (cmd.out_sel)
                pfst_pkg::OS_LIT_IN: begin
                    out_text <= in_ch;
                end
                pfst_pkg::OS_LIT_HELD: begin
                    out_text <= ch_reg;
                end
                pfst_pkg::OS_DESC: begin
                    out_kind  <= pfst_pkg::KIND_SPEC;
                    out_flags <= flags_reg;
                    out_width <= width_reg;
                    out_prec  <= prec_reg;
                    out_conv  <= in_ch;
                end
                pfst_pkg::OS_ECHO: begin
                    out_kind <= pfst_pkg::KIND_ECHO;
                    out_text <= rd_data_reg;
                end
                pfst_pkg::OS_END: begin
                    out_kind <= pfst_pkg::KIND_END;
                    out_ovf  <= lost_reg;
                end
                default: begin
                    out_kind <= pfst_pkg::KIND_END;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(ECHO_DEPTH))
        else $error("echo count beyond buffer depth");

    a_lost_full: assert property (@(posedge aclk) disable iff (!aresetn)
        lost_reg |-> (cnt_reg == CW'(ECHO_DEPTH)))
        else $error("echo overflow flagged with room left");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (idx_reg < cnt_reg))
        else $error("echo read past stored text");

endmodule

### rtl/core/printf_format_spec_tokenizer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// printf_format_spec_tokenizer_unit: printf format specifier tokenizer
// Splits a format string into literal bytes, specifier descriptors and
// echoed text of rejected specifiers.
// ============================================================================
// Usage:
// Format string bytes enter on the s_ channel, one byte per beat, with
// s_tlast on the final byte of a string. Results leave on the m_ channel;
// m_tuser carries the result kind and m_tlast marks the last result caused
// by one input byte. The cfg_ channel writes the single size-type register
// (t, j and z select long when 1, long long when 0); it is always ready and
// must be written only while the block is idle.
// Literal bytes and closing conversion bytes give their result in the
// cycle after they are accepted. These bytes and bytes absorbed into an
// open specifier before the end of the string leave s_tready high, so
// ordinary text streams at one byte per cycle while the receiver keeps up.
// After the byte that rejects a specifier, or a last byte that leaves one
// open, s_tready stays low while each echoed byte is read from the echo
// buffer (single registered read port) and sent, as the exhausted echo is
// found, and for the end marker and any held literal or second marker.
// After reset the block is in literal mode with the register set to 1 and
// no result pending. When the receiver stalls, the output register holds
// its beat and s_tready falls until the result is taken.
// ============================================================================
module printf_format_spec_tokenizer_unit #(
    parameter int ECHO_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] text_char, [20:8] spec_flags, [36:21] field_width,
    // [52:37] field_precision, [60:53] conversion, [61] echo_overflow,
    // [63:62] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // run_end
    // Configuration register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // size_types_are_long
);

    pfst_pkg::cmd_t              cmd;
    pfst_pkg::status_t           status;
    logic [7:0]                  out_text;
    logic [pfst_pkg::FLAG_W-1:0] out_flags;
    logic [pfst_pkg::NUM_W-1:0]  out_width;
    logic [pfst_pkg::NUM_W-1:0]  out_prec;
    logic [7:0]                  out_conv;
    logic                        out_ovf;

    // The register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // The controller decides on each accepted byte and runs the echo
    // sequence of a rejected specifier.
    pfst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the specifier state, echo buffer and result register.
    pfst_dpath #(
        .ECHO_DEPTH (ECHO_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_ch     (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_text  (out_text),
        .out_flags (out_flags),
        .out_width (out_width),
        .out_prec  (out_prec),
        .out_conv  (out_conv),
        .out_ovf   (out_ovf),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_ovf, out_conv, out_prec, out_width, out_flags, out_text};

endmodule

### tb/format_token_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// format_token_checker: result predictor and comparator of the tokenizer
// Watches the byte, result and register channels. Every accepted input beat
// is run through a bit-accurate model of the tokenizer, and every result beat
// is compared, field by field, with the oldest predicted token.
// ============================================================================
module format_token_checker #(
    parameter int ECHO_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] text_char, [20:8] spec_flags, [36:21] field_width,
    // [52:37] field_precision, [60:53] conversion, [61] echo_overflow
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,   // run_end
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          mismatch_count,
    output int          tokens_outstanding
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  text;
        logic [12:0] flags;
        logic [15:0] fwidth;
        logic [15:0] fprec;
        logic [7:0]  conv;
        logic        ovf;
        logic        run_end;
    } token_t;

    token_t      expected_tokens[$];
    token_t      head;

    // Model of the parser state.
    pfst_pkg::phase_t phase;
    logic [12:0] spec_flags;
    int          width_acc;
    int          prec_acc;
    logic [7:0]  echo_mem [ECHO_DEPTH];
    int          echo_cnt;
    logic        echo_lost;
    logic        size_long;
    int          step_count;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_conversion(logic [7:0] c);
        case (c)
            "d", "i", "u", "x", "X", "o", "b", "f", "F", "e", "E", "g", "G",
            "c", "s", "p", pfst_pkg::CH_PCT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int add_digit(int acc, logic [7:0] c);
        int v;
        v = acc * 10 + (c - "0");
        return (v > pfst_pkg::SAT_MAX) ? int'(pfst_pkg::SAT_MAX) : v;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] text, logic [12:0] flags,
                                 int fw, int fp, logic [7:0] conv, logic ovf);
        token_t t;
        t.kind    = kind;
        t.text    = text;
        t.flags   = flags;
        t.fwidth  = fw[15:0];
        t.fprec   = fp[15:0];
        t.conv    = conv;
        t.ovf     = ovf;
        t.run_end = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
        step_count++;
    endfunction

    function automatic void literal_byte(logic [7:0] c);
        if (c == pfst_pkg::CH_PCT) begin
            phase      = pfst_pkg::PH_FLAGS;
            spec_flags = '0;
            width_acc  = 0;
            prec_acc   = 0;
            echo_cnt   = 0;
            echo_lost  = 1'b0;
        end else begin
            emit(pfst_pkg::KIND_LIT, c, '0, 0, 0, '0, 1'b0);
        end
    endfunction

    function automatic void flush_rejected();
        int k;
        for (k = 0; k < echo_cnt && k < ECHO_DEPTH; k++)
            emit(pfst_pkg::KIND_ECHO, echo_mem[k], '0, 0, 0, '0, 1'b0);
        emit(pfst_pkg::KIND_END, '0, '0, 0, 0, '0, echo_lost);
        phase = pfst_pkg::PH_LIT;
    endfunction

    // Decides what an open specifier does with one byte and updates it.
    function automatic pfst_pkg::take_t classify_byte(logic [7:0] c);
        pfst_pkg::phase_t ph;
        ph = phase;
        if (ph == pfst_pkg::PH_FLAGS) begin
            case (c)
                "0": begin spec_flags[pfst_pkg::FB_ZEROPAD] = 1'b1; return pfst_pkg::TK_CONSUME; end
                "-": begin spec_flags[pfst_pkg::FB_LEFT] = 1'b1; return pfst_pkg::TK_CONSUME; end
                "+": begin spec_flags[pfst_pkg::FB_PLUS] = 1'b1; return pfst_pkg::TK_CONSUME; end
                " ": begin spec_flags[pfst_pkg::FB_SPACE] = 1'b1; return pfst_pkg::TK_CONSUME; end
                "#": begin spec_flags[pfst_pkg::FB_HASH] = 1'b1; return pfst_pkg::TK_CONSUME; end
                default: ;
            endcase
            if (is_digit(c)) begin
                spec_flags[pfst_pkg::FB_HASW] = 1'b1;
                width_acc = c - "0";
                phase = pfst_pkg::PH_WIDTH;
                return pfst_pkg::TK_CONSUME;
            end
            if (c == pfst_pkg::CH_STAR) begin
                spec_flags[pfst_pkg::FB_HASW]  = 1'b1;
                spec_flags[pfst_pkg::FB_WSTAR] = 1'b1;
                phase = pfst_pkg::PH_WSTAR;
                return pfst_pkg::TK_CONSUME;
            end
        end
        if (ph == pfst_pkg::PH_WIDTH && is_digit(c)) begin
            width_acc = add_digit(width_acc, c);
            return pfst_pkg::TK_CONSUME;
        end
        if ((ph == pfst_pkg::PH_FLAGS || ph == pfst_pkg::PH_WIDTH || ph == pfst_pkg::PH_WSTAR)
                && c == pfst_pkg::CH_DOT) begin
            spec_flags[pfst_pkg::FB_HASP] = 1'b1;
            phase = pfst_pkg::PH_DOT;
            return pfst_pkg::TK_CONSUME;
        end
        if (ph == pfst_pkg::PH_DOT && is_digit(c)) begin
            prec_acc = c - "0";
            phase = pfst_pkg::PH_PREC;
            return pfst_pkg::TK_CONSUME;
        end
        if (ph == pfst_pkg::PH_DOT && c == pfst_pkg::CH_STAR) begin
            spec_flags[pfst_pkg::FB_PSTAR] = 1'b1;
            phase = pfst_pkg::PH_PSTAR;
            return pfst_pkg::TK_CONSUME;
        end
        if (ph == pfst_pkg::PH_PREC && is_digit(c)) begin
            prec_acc = add_digit(prec_acc, c);
            return pfst_pkg::TK_CONSUME;
        end
        if (ph >= pfst_pkg::PH_FLAGS && ph <= pfst_pkg::PH_PSTAR) begin
            case (c)
                "l": begin
                    spec_flags[pfst_pkg::FB_LONG] = 1'b1;
                    phase = pfst_pkg::PH_L;
                    return pfst_pkg::TK_CONSUME;
                end
                "h": begin
                    spec_flags[pfst_pkg::FB_SHORT] = 1'b1;
                    phase = pfst_pkg::PH_H;
                    return pfst_pkg::TK_CONSUME;
                end
                "t", "j", "z": begin
                    spec_flags[size_long ? pfst_pkg::FB_LONG : pfst_pkg::FB_LLONG] = 1'b1;
                    phase = pfst_pkg::PH_SPEC;
                    return pfst_pkg::TK_CONSUME;
                end
                default: ;
            endcase
        end
        if (ph == pfst_pkg::PH_L && c == "l") begin
            spec_flags[pfst_pkg::FB_LLONG] = 1'b1;
            phase = pfst_pkg::PH_SPEC;
            return pfst_pkg::TK_CONSUME;
        end
        if (ph == pfst_pkg::PH_H && c == "h") begin
            spec_flags[pfst_pkg::FB_CHAR] = 1'b1;
            phase = pfst_pkg::PH_SPEC;
            return pfst_pkg::TK_CONSUME;
        end
        return is_conversion(c) ? pfst_pkg::TK_CLOSE : pfst_pkg::TK_REJECT;
    endfunction

    // Predicts the tokens caused by one input beat.
    function automatic void tokenize_byte(logic [7:0] c, logic fin);
        pfst_pkg::take_t verdict;
        step_count = 0;
        if (phase == pfst_pkg::PH_LIT) begin
            literal_byte(c);
        end else begin
            verdict = classify_byte(c);
            case (verdict)
                pfst_pkg::TK_CLOSE: begin
                    emit(pfst_pkg::KIND_SPEC, '0, spec_flags, width_acc, prec_acc, c, 1'b0);
                    phase = pfst_pkg::PH_LIT;
                end
                pfst_pkg::TK_CONSUME: begin
                    if (echo_cnt < ECHO_DEPTH) begin
                        echo_mem[echo_cnt] = c;
                        echo_cnt++;
                    end else begin
                        echo_lost = 1'b1;
                    end
                end
                default: begin
                    flush_rejected();
                    literal_byte(c);
                end
            endcase
        end
        if (fin && phase != pfst_pkg::PH_LIT)
            flush_rejected();
        if (step_count > 0)
            expected_tokens[expected_tokens.size() - 1].run_end = 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_tokens.delete();
            phase      = pfst_pkg::PH_LIT;
            spec_flags = '0;
            width_acc  = 0;
            prec_acc   = 0;
            echo_cnt   = 0;
            echo_lost  = 1'b0;
            size_long  = 1'b1;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, %s 0x%0h",
                             $time, "actual data", m_tdata);
                    mismatch_count++;
                end else begin
                    head = expected_tokens.pop_front();
                    check_field("kind", 16'(head.kind), 16'(m_tuser));
                    check_field("text_char", 16'(head.text), 16'(m_tdata[7:0]));
                    check_field("spec_flags", 16'(head.flags), 16'(m_tdata[20:8]));
                    check_field("field_width", head.fwidth, m_tdata[36:21]);
                    check_field("field_precision", head.fprec, m_tdata[52:37]);
                    check_field("conversion", 16'(head.conv), 16'(m_tdata[60:53]));
                    check_field("echo_overflow", 16'(head.ovf), 16'(m_tdata[61]));
                    check_field("tdata padding", '0, 16'(m_tdata[63:62]));
                    check_field("run_end", 16'(head.run_end), 16'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready)
                size_long = cfg_data;
        end
        tokens_outstanding = expected_tokens.size();
    end

endmodule

### tb/tb_printf_format_spec_tokenizer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_printf_format_spec_tokenizer_unit: testbench of the format tokenizer
// Feeds directed and random format strings, mostly well-formed specifiers
// with random content plus broken specifiers and noise, under random stalls
// on both channels and with the size-type register set both ways. A checker
// beside the block predicts every result beat and compares it.
// ============================================================================
module tb_printf_format_spec_tokenizer_unit;

    localparam int ECHO_DEPTH     = 16;
    // Cycles to let pass once every expected beat has arrived. A rejected
    // specifier of a full echo buffer needs a long echo sequence, and bytes
    // swallowed into a specifier make no beat at all, so leave some margin.
    localparam int DRAIN_CYCLES   = 48;
    // Length of the forced receiver stall that backs the block up.
    localparam int RX_HOLD_CYCLES = 150;
    // Cycles without any beat on any channel before the run is abandoned.
    // The longest legal quiet stretch is the forced stall above.
    localparam int STUCK_LIMIT    = 1000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] ch
    logic        s_tlast;     // last
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;     // text, flags, width, precision, conversion, overflow
    logic [1:0]  m_tuser;     // [1:0] kind
    logic        m_tlast;     // run_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    int          mismatch_count;
    int          tokens_outstanding;
    int          stuck_cycles = 0;

    // Random idling on both channels is switched off for one whole phase.
    logic        idle_en = 1'b1;
    // Set by the stimulus to make the receiver stall for a long stretch.
    logic        rx_hold = 1'b0;
    // Bytes of the chunk of format text being sent.
    logic [7:0]  burst[$];

    // 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    printf_format_spec_tokenizer_unit #(
        .ECHO_DEPTH(ECHO_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    format_token_checker #(
        .ECHO_DEPTH(ECHO_DEPTH)
    ) checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .tokens_outstanding(tokens_outstanding)
    );

    // Offers one byte and returns at the falling edge after its beat. The
    // valid is left high so that a following byte continues without a gap;
    // the next call or the drain lowers it when needed.
    task automatic send_byte(input logic [7:0] ch, input logic fin);
        while (idle_en && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_text(input string text, input logic fin);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], fin && (i == text.len() - 1));
    endtask

    // Appends one byte to the chunk being built.
    function automatic void add_byte(input logic [7:0] b);
        burst.insert(burst.size(), b);
    endfunction

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++)
            add_byte(text[i]);
    endtask

    // Stops offering bytes, waits for every predicted beat to arrive and then
    // lets the block settle, so that it is idle afterwards.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tokens_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_size_mode(input logic is_long);
        cfg_valid <= 1'b1;
        cfg_data  <= is_long;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends random format text in chunks: half are well-formed specifiers
    // with random flags, width, precision, length and conversion, a quarter
    // are the same cut short and ended by a random byte, and the rest are
    // plain text and raw bytes. The end of string lands at random, and the
    // phase always ends with one so that no specifier stays open.
    task automatic send_random(input int count);
        string      flag_set = "-+ #0";
        string      conv_set = "diuxXobfFeEgGcsp%";
        int         sent;
        int         pick;
        int         ndig;
        int         keep;
        sent = 0;
        while (sent < count) begin
            burst.delete();
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                add_byte(pfst_pkg::CH_PCT);
                repeat ($urandom_range(0, 3))
                    add_byte(flag_set[$urandom_range(0, 4)]);
                // Long digit runs saturate the numbers and, in a broken
                // specifier, overflow the echo buffer.
                if ($urandom_range(0, 99) < ((pick >= 50) ? 30 : 8))
                    ndig = $urandom_range(14, 22);
                else
                    ndig = $urandom_range(1, 3);
                case ($urandom_range(0, 3))
                    0: ;
                    1: add_byte(pfst_pkg::CH_STAR);
                    default: repeat (ndig) add_byte(8'($urandom_range(48, 57)));
                endcase
                if ($urandom_range(0, 1)) begin
                    add_byte(pfst_pkg::CH_DOT);
                    case ($urandom_range(0, 4))
                        0: ;
                        1: add_byte(pfst_pkg::CH_STAR);
                        default: repeat (ndig) add_byte(8'($urandom_range(48, 57)));
                    endcase
                end
                case ($urandom_range(0, 9))
                    0: push_text("l");
                    1: push_text("ll");
                    2: push_text("h");
                    3: push_text("hh");
                    4: push_text("t");
                    5: push_text("j");
                    6: push_text("z");
                    default: ;
                endcase
                add_byte(conv_set[$urandom_range(0, 16)]);
                if (pick >= 50) begin
                    keep = $urandom_range(1, burst.size() - 1);
                    while (burst.size() > keep)
                        burst.delete(burst.size() - 1);
                    add_byte(8'($urandom_range(0, 255)));
                end
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(32, 126)));
            end else begin
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            foreach (burst[i]) begin
                send_byte(burst[i], $urandom_range(0, 24) == 0);
                sent++;
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // The receiver decides its ready at every falling edge. A hold request
    // keeps it low for a long stretch while the sender goes on offering, so
    // the output register fills and the block has to stall its input.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                rx_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= !(idle_en && $urandom_range(0, 99) < 26);
        end
    end

    // Gives up when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_printf_format_spec_tokenizer_unit failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, with t, j and z meaning long.
        write_size_mode(1'b1);
        // Lowest and highest byte values as literals, the second ending a string.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // All flags, star width, star precision and the char length.
        send_text("%-+ #0*.*hhd", 1'b0);
        // A percent sign as conversion.
        send_text("%%", 1'b0);
        // A digit after a star width rejects the specifier; the digit then
        // comes out as a literal that also ends the string.
        send_text("%*5", 1'b1);
        // A percent sign after a length letter closes the specifier as its
        // conversion, even on the last byte of a string.
        send_text("%l%", 1'b1);
        // Precision beyond the saturation limit.
        send_text("%.70000f", 1'b1);
        wait_drained();

        // Random part with long long size types, random idling and one long
        // receiver stall right at its start.
        write_size_mode(1'b0);
        rx_hold = 1'b1;
        send_random(80);
        wait_drained();

        // No idling on either side for this whole phase.
        write_size_mode(1'b1);
        idle_en = 1'b0;
        send_random(75);
        wait_drained();

        write_size_mode(1'b0);
        idle_en = 1'b1;
        send_random(70);
        wait_drained();

        if (mismatch_count == 0 && tokens_outstanding == 0) begin
            $display("tb_printf_format_spec_tokenizer_unit passed");
        end else begin
            $display("tb_printf_format_spec_tokenizer_unit failed");
        end
        $finish;
    end

endmodule
